// ----- sv/tkss_pkg.sv -----
// ----------------------------------------------------------------------------
// tkss_pkg: shared types and constants for the tagged key shell sorter
// holds payload structs, state enum and double compare function
// ----------------------------------------------------------------------------
`default_nettype none
package tkss_pkg;
  localparam int MAX_ITEMS  = 64;
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int GAP_W      = 12;
  localparam int GAP_N      = 7;
  localparam int GIDX_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_COUNT = 3'd0;

  typedef struct packed {
    logic [63:0] key_bits;
    logic [15:0] tag;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] sorted_key_bits;
    logic [15:0] sorted_tag;
    logic        run_last;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SCAN, ST_PASS, ST_JRD, ST_JWAIT, ST_CMP, ST_CWAIT, ST_CDEC,
    ST_PUT, ST_ORD, ST_OWAIT, ST_OUT, ST_ERR
  } state_t;

  // a < b as IEEE doubles, NaN not handled, -0 equals +0
  function automatic logic key_less(input logic [63:0] a, input logic [63:0] b);
    logic a_zero, b_zero;
    a_zero = (a[62:0] == 63'd0);
    b_zero = (b[62:0] == 63'd0);
    if (a_zero && b_zero) key_less = 1'b0;
    else if (a[63] != b[63]) key_less = a[63];
    else if (!a[63]) key_less = (a[62:0] < b[62:0]);
    else key_less = (a[62:0] > b[62:0]);
  endfunction
endpackage
`default_nettype wire

// ----- sv/tkss_ram.sv -----
// ----------------------------------------------------------------------------
// tkss_ram: element store
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module tkss_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [tkss_pkg::ADDR_W-1:0] waddr,
  input  wire tkss_pkg::entry_t            wdata,
  input  wire logic [tkss_pkg::ADDR_W-1:0] raddr,
  output tkss_pkg::entry_t                 rdata
);
  import tkss_pkg::*;
  entry_t mem [MAX_ITEMS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/tagged_key_shell_sorter_top.sv -----
// ----------------------------------------------------------------------------
// tagged_key_shell_sorter_top: loads (key, tag) requests and emits them sorted
// shell sort run in place over a single-port-pair element store
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_data): one request per cycle while
//   loading; each is written to the store. a request with is_last closes
//   the load and starts the sort; requests past 64 are dropped.
//   out channel (out_valid/out_ready/out_data): the sorted run, ascending
//   key, run_last on the final one. if no gap entry in use reaches the
//   count, a single result with status 1 is sent instead.
//   cfg port (cfg_we/cfg_index/cfg_data): index 0 is gap_count, 1..7 are
//   gap_0..gap_6; write only while idle.
// sequencing:
//   the sort is a sequencer around the store: each compare-move step is a
//   registered read of the neighbour plus a compare (states CMP, CWAIT and
//   CDEC), and each inserted element adds a fetch (JRD, JWAIT) and a
//   write-back (PUT). the gap scan tries the entries in turn, and each pass
//   begins in PASS. each emitted result goes through ORD, OWAIT and OUT;
//   ORD waits while the output register is full and not taken.
// reset clears control, counts and the gap table to its defaults; the
// store itself is not cleared. when the receiver stalls the sequencer
// holds on the output register and no new request is taken until done.
// ----------------------------------------------------------------------------
`default_nettype none
module tagged_key_shell_sorter_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire tkss_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output tkss_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [tkss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tkss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tkss_pkg::*;

  // configuration registers
  logic [GIDX_W-1:0] gap_count;
  logic [GAP_W-1:0]  gaps [GAP_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_count <= 3'd5;
      gaps[0] <= 12'd1;    gaps[1] <= 12'd4;   gaps[2] <= 12'd13;
      gaps[3] <= 12'd40;   gaps[4] <= 12'd121; gaps[5] <= 12'd364;
      gaps[6] <= 12'd1093;
    end else if (cfg_we) begin
      if (cfg_index == REG_GAP_COUNT) gap_count <= cfg_data[GIDX_W-1:0];
      else gaps[cfg_index - 3'd1] <= cfg_data;
    end
  end

  // sequencer registers
  state_t            state, state_next;
  logic [CNT_W-1:0]  count;      // items loaded
  logic [GIDX_W-1:0] gidx;       // current gap entry
  logic [CNT_W-1:0]  j;          // outer index of a pass
  logic [CNT_W-1:0]  pos;        // hole position
  entry_t            held;       // element being inserted
  logic              out_full;

  // store ports
  logic             we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;

  tkss_ram u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic [CNT_W:0] gap_ext;
  logic [CNT_W:0] cur_gap;
  assign cur_gap = {1'b0, gaps[gidx][CNT_W-1:0]};
  assign gap_ext = (gaps[gidx] > GAP_W'(MAX_ITEMS)) ? (CNT_W+1)'(MAX_ITEMS + 1) : cur_gap;

  logic in_acc;
  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state == ST_LOAD);
  assign out_valid = out_full;

  logic [CNT_W:0] pos_m_gap;
  assign pos_m_gap = {1'b0, pos} - gap_ext;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (in_acc && in_data.is_last) state_next = ST_SCAN;
      ST_SCAN: begin
        if (gidx >= gap_count) state_next = ST_ERR;
        else if ({1'b0, gaps[gidx]} >= (GAP_W+1)'(count)) state_next = ST_PASS;
      end
      ST_PASS: begin
        if (gaps[gidx] == '0 || gap_ext >= {1'b0, count}) begin
          if (gidx == '0) state_next = ST_ORD;
        end else state_next = ST_JRD;
      end
      ST_JRD:   state_next = ST_JWAIT;
      ST_JWAIT: state_next = ST_CMP;
      ST_CMP:   state_next = (pos_m_gap[CNT_W] ) ? ST_PUT : ST_CWAIT;
      ST_CWAIT: state_next = ST_CDEC;
      ST_CDEC:  state_next = key_less(held.key, rdata.key) ? ST_CMP : ST_PUT;
      ST_PUT: begin
        if (j + CNT_W'(1) >= count) begin
          state_next = (gidx == '0) ? ST_ORD : ST_PASS;
        end else state_next = ST_JRD;
      end
      ST_ORD:   if (!out_full || out_ready) state_next = ST_OWAIT;
      ST_OWAIT: state_next = ST_OUT;
      ST_OUT:   state_next = (j + CNT_W'(1) == count) ? ST_LOAD : ST_ORD;
      ST_ERR:   if (!out_full || out_ready) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // store port control
  always_comb begin
    we    = 1'b0;
    waddr = pos[ADDR_W-1:0];
    wdata = held;
    raddr = j[ADDR_W-1:0];
    case (state)
      ST_LOAD: begin
        we    = in_acc && (count < CNT_W'(MAX_ITEMS));
        waddr = count[ADDR_W-1:0];
        wdata = '{key: in_data.key_bits, tag: in_data.tag};
      end
      // neighbour address held until its data lands
      ST_CMP, ST_CWAIT: raddr = pos_m_gap[ADDR_W-1:0];
      ST_CDEC: begin
        // shift neighbour up into the hole
        we    = key_less(held.key, rdata.key);
        waddr = pos[ADDR_W-1:0];
        wdata = rdata;
      end
      ST_PUT:  we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      gidx     <= '0;
      j        <= '0;
      pos      <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT || (state == ST_ERR && (!out_full || out_ready))) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (in_acc && count < CNT_W'(MAX_ITEMS)) count <= count + CNT_W'(1);
          gidx <= '0;
        end
        ST_SCAN: if (gidx < gap_count && {1'b0, gaps[gidx]} < (GAP_W+1)'(count))
                   gidx <= gidx + GIDX_W'(1);
        ST_PASS: begin
          if (gaps[gidx] == '0 || gap_ext >= {1'b0, count}) begin
            if (gidx != '0) gidx <= gidx - GIDX_W'(1);
            else j <= '0;
          end else j <= gap_ext[CNT_W-1:0];
        end
        ST_JWAIT: begin
          held <= rdata;
          pos  <= j;
        end
        ST_CDEC: if (key_less(held.key, rdata.key)) pos <= pos_m_gap[CNT_W-1:0];
        ST_PUT: begin
          if (j + CNT_W'(1) >= count) begin
            if (gidx != '0) gidx <= gidx - GIDX_W'(1);
            j <= '0;
          end else j <= j + CNT_W'(1);
        end
        ST_OUT: begin
          out_data <= '{sorted_key_bits: rdata.key, sorted_tag: rdata.tag,
                        run_last: (j + CNT_W'(1) == count), status: 1'b0};
          j <= j + CNT_W'(1);
          if (j + CNT_W'(1) == count) count <= '0;
        end
        ST_ERR: if (!out_full || out_ready) begin
          out_data <= '{sorted_key_bits: '0, sorted_tag: '0,
                        run_last: 1'b1, status: 1'b1};
          count    <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
